// ----- rtl/sqlx_pkg.sv -----
// Shared types, token codes and keyword table for the SQL token lexer.
package sqlx_pkg;

  localparam int PosW     = 16;
  localparam int KwMaxLen = 7;
  localparam int KwIdxW   = $clog2(KwMaxLen);
  localparam int KwLenW   = $clog2(KwMaxLen + 1);
  localparam int KwW      = KwMaxLen * 8;
  localparam int NumKw    = 38;
  localparam int MaxTok   = 4;
  localparam int QDepth   = 8;
  localparam int QPtrW    = $clog2(QDepth);

  localparam logic [5:0] KindLParen = 6'd0;
  localparam logic [5:0] KindRParen = 6'd1;
  localparam logic [5:0] KindComma  = 6'd2;
  localparam logic [5:0] KindDot    = 6'd3;
  localparam logic [5:0] KindSemi   = 6'd4;
  localparam logic [5:0] KindPlus   = 6'd5;
  localparam logic [5:0] KindMinus  = 6'd6;
  localparam logic [5:0] KindStar   = 6'd7;
  localparam logic [5:0] KindSlash  = 6'd8;
  localparam logic [5:0] KindEq     = 6'd9;
  localparam logic [5:0] KindNe     = 6'd10;
  localparam logic [5:0] KindLt     = 6'd11;
  localparam logic [5:0] KindLe     = 6'd12;
  localparam logic [5:0] KindGt     = 6'd13;
  localparam logic [5:0] KindGe     = 6'd14;
  localparam logic [5:0] KindConcat = 6'd15;
  localparam logic [5:0] KindIdent  = 6'd16;
  localparam logic [5:0] KindQName  = 6'd17;
  localparam logic [5:0] KindInt    = 6'd18;
  localparam logic [5:0] KindFloat  = 6'd19;
  localparam logic [5:0] KindString = 6'd20;
  localparam logic [5:0] KindKw0    = 6'd21;
  localparam logic [5:0] KindEnd    = 6'd59;
  localparam logic [5:0] KindError  = 6'd60;

  localparam logic [2:0] ErrNone   = 3'd0;
  localparam logic [2:0] ErrChar   = 3'd1;
  localparam logic [2:0] ErrBang   = 3'd2;
  localparam logic [2:0] ErrBar    = 3'd3;
  localparam logic [2:0] ErrString = 3'd4;
  localparam logic [2:0] ErrQName  = 3'd5;

  localparam logic [PosW-1:0] PosMax = {PosW{1'b1}};

  typedef logic [KwMaxLen-1:0][7:0] kbuf_t;

  localparam logic [KwW-1:0] KwTab [NumKw] = '{
    "SELECT", "FROM", "WHERE", "INSERT", "INTO", "VALUES", "UPDATE", "SET",
    "DELETE", "CREATE", "ALTER", "DROP", "TABLE", "INDEX", "SCHEMA",
    "PRIMARY", "KEY", "UNIQUE", "NULL", "TRUE", "FALSE", "AND", "OR", "NOT",
    "IS", "IN", "BETWEEN", "INNER", "LEFT", "JOIN", "ON", "BY", "ORDER",
    "GROUP", "ASC", "DESC", "LIMIT", "AS"
  };

  localparam int KwLen [NumKw] = '{
    6, 4, 5, 6, 4, 6, 6, 3, 6, 6, 5, 4, 5, 5, 6, 7, 3, 6, 4, 4, 5, 3, 2, 3,
    2, 2, 7, 5, 4, 4, 2, 2, 5, 5, 3, 4, 5, 2
  };

  typedef struct packed {
    logic [5:0]      kind;
    logic [2:0]      err;
    logic [PosW-1:0] line;
    logic [PosW-1:0] col;
    logic [PosW-1:0] len;
    logic            last;
  } tok_t;

  typedef struct packed {
    logic [2:0]             cnt;
    tok_t [MaxTok-1:0]      slot;
  } push_t;

  function automatic logic [5:0] kw_lookup(kbuf_t b, logic [KwLenW-1:0] len);
    logic [KwW-1:0] w;
    logic [5:0]     k;
    w = '0;
    k = KindIdent;
    for (int i = 0; i < KwMaxLen; i++) begin
      if (i < int'(len)) w = {w[KwW-9:0], b[i]};
    end
    for (int j = NumKw - 1; j >= 0; j--) begin
      if (w == KwTab[j] && len == KwLenW'(KwLen[j])) k = 6'(int'(KindKw0) + j);
    end
    return k;
  endfunction

endpackage

// ----- rtl/sqlx_if.sv -----
// Byte and token channel interfaces.
interface sqlx_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_source;
  modport source (output valid, data_byte, end_of_source, input ready);
  modport sink (input valid, data_byte, end_of_source, output ready);
endinterface

interface sqlx_tok_if import sqlx_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [5:0]      token_kind;
  logic [2:0]      error_code;
  logic [PosW-1:0] start_line;
  logic [PosW-1:0] start_column;
  logic [PosW-1:0] token_length;
  logic            last_of_run;
  modport source (output valid, token_kind, error_code, start_line, start_column,
                  token_length, last_of_run, input ready);
  modport sink (input valid, token_kind, error_code, start_line, start_column,
                token_length, last_of_run, output ready);
endinterface

// ----- rtl/sqlx_front.sv -----
// Lexer front end: scans one byte per beat and produces up to four tokens.
module sqlx_front import sqlx_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  sqlx_byte_if.sink   byte_i,
  input  logic        room_i,
  output push_t       push_o
);

  typedef enum logic [17:0] {
    M_IDLE       = 18'h00001,
    M_MINUS      = 18'h00002,
    M_LINE       = 18'h00004,
    M_SLASH      = 18'h00008,
    M_BLOCK      = 18'h00010,
    M_BLOCK_STAR = 18'h00020,
    M_EQ         = 18'h00040,
    M_BANG       = 18'h00080,
    M_LT         = 18'h00100,
    M_GT         = 18'h00200,
    M_BAR        = 18'h00400,
    M_STR        = 18'h00800,
    M_STR_Q      = 18'h01000,
    M_QNAME      = 18'h02000,
    M_IDENT      = 18'h04000,
    M_INT        = 18'h08000,
    M_INT_DOT    = 18'h10000,
    M_FLOAT      = 18'h20000
  } mode_e;

  mode_e           mode_q, mode_d;
  kbuf_t           kbuf_q, kbuf_d;
  logic [PosW-1:0] line_q, line_d, col_q, col_d;
  logic [PosW-1:0] sline_q, sline_d, scol_q, scol_d;
  logic [PosW-1:0] plen_q, plen_d;
  logic            err_q, err_d;
  tok_t [MaxTok-1:0] slot;
  logic [2:0]      n;
  logic            acc;

  function automatic logic [PosW-1:0] sat_inc(logic [PosW-1:0] v);
    return (v == PosMax) ? v : v + 1'b1;
  endfunction

  function automatic logic [PosW-1:0] sat_add(logic [PosW-1:0] a, logic [PosW-1:0] b);
    logic [PosW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[PosW] ? PosMax : s[PosW-1:0];
  endfunction

  function automatic logic is_dig(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alp(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic tok_t mk(logic [5:0] k, logic [2:0] e, logic [PosW-1:0] l,
                              logic [PosW-1:0] c, logic [PosW-1:0] len);
    tok_t t;
    t.kind = k;
    t.err  = e;
    t.line = l;
    t.col  = c;
    t.len  = len;
    t.last = 1'b0;
    return t;
  endfunction

  assign byte_i.ready = room_i;
  assign acc = byte_i.valid & room_i;

  always_comb begin
    logic [7:0]  c;
    logic        fresh;
    logic [5:0]  k;
    logic [1:0]  li;
    c = byte_i.data_byte;
    mode_d  = mode_q;
    kbuf_d  = kbuf_q;
    line_d  = line_q;
    col_d   = col_q;
    sline_d = sline_q;
    scol_d  = scol_q;
    plen_d  = plen_q;
    err_d   = err_q;
    slot    = '0;
    n       = '0;
    fresh   = 1'b0;
    k       = KindIdent;

    if (!err_q) begin
      unique case (mode_q)
        M_MINUS: begin
          if (c == "-") mode_d = M_LINE;
          else begin
            slot[n[1:0]] = mk(KindMinus, ErrNone, sline_d, scol_d, PosW'(1)); n = n + 3'd1;
            mode_d = M_IDLE; fresh = 1'b1;
          end
        end
        M_LINE: if (c == 8'h0a) mode_d = M_IDLE;
        M_SLASH: begin
          if (c == "*") mode_d = M_BLOCK;
          else begin
            slot[n[1:0]] = mk(KindSlash, ErrNone, sline_d, scol_d, PosW'(1)); n = n + 3'd1;
            mode_d = M_IDLE; fresh = 1'b1;
          end
        end
        M_BLOCK: if (c == "*") mode_d = M_BLOCK_STAR;
        M_BLOCK_STAR: begin
          if (c == "/") mode_d = M_IDLE;
          else if (c != "*") mode_d = M_BLOCK;
        end
        M_EQ: begin
          if (c == "=") begin
            slot[n[1:0]] = mk(KindEq, ErrNone, sline_d, scol_d, PosW'(2)); n = n + 3'd1;
          end else begin
            slot[n[1:0]] = mk(KindEq, ErrNone, sline_d, scol_d, PosW'(1)); n = n + 3'd1;
            fresh = 1'b1;
          end
          mode_d = M_IDLE;
        end
        M_BANG: begin
          if (c == "=") begin
            slot[n[1:0]] = mk(KindNe, ErrNone, sline_d, scol_d, PosW'(2)); n = n + 3'd1;
          end else begin
            slot[n[1:0]] = mk(KindError, ErrBang, sline_d, scol_d, PosW'(1)); n = n + 3'd1;
            err_d = 1'b1;
          end
          mode_d = M_IDLE;
        end
        M_LT: begin
          if (c == "=") begin
            slot[n[1:0]] = mk(KindLe, ErrNone, sline_d, scol_d, PosW'(2)); n = n + 3'd1;
          end else if (c == ">") begin
            slot[n[1:0]] = mk(KindNe, ErrNone, sline_d, scol_d, PosW'(2)); n = n + 3'd1;
          end else begin
            slot[n[1:0]] = mk(KindLt, ErrNone, sline_d, scol_d, PosW'(1)); n = n + 3'd1;
            fresh = 1'b1;
          end
          mode_d = M_IDLE;
        end
        M_GT: begin
          if (c == "=") begin
            slot[n[1:0]] = mk(KindGe, ErrNone, sline_d, scol_d, PosW'(2)); n = n + 3'd1;
          end else begin
            slot[n[1:0]] = mk(KindGt, ErrNone, sline_d, scol_d, PosW'(1)); n = n + 3'd1;
            fresh = 1'b1;
          end
          mode_d = M_IDLE;
        end
        M_BAR: begin
          if (c == "|") begin
            slot[n[1:0]] = mk(KindConcat, ErrNone, sline_d, scol_d, PosW'(2)); n = n + 3'd1;
          end else begin
            slot[n[1:0]] = mk(KindError, ErrBar, sline_d, scol_d, PosW'(1)); n = n + 3'd1;
            err_d = 1'b1;
          end
          mode_d = M_IDLE;
        end
        M_STR: begin
          plen_d = sat_inc(plen_d);
          if (c == "'") mode_d = M_STR_Q;
        end
        M_STR_Q: begin
          if (c == "'") begin
            plen_d = sat_inc(plen_d);
            mode_d = M_STR;
          end else begin
            slot[n[1:0]] = mk(KindString, ErrNone, sline_d, scol_d, plen_d); n = n + 3'd1;
            mode_d = M_IDLE; fresh = 1'b1;
          end
        end
        M_QNAME: begin
          plen_d = sat_inc(plen_d);
          if (c == "\"") begin
            slot[n[1:0]] = mk(KindQName, ErrNone, sline_d, scol_d, plen_d); n = n + 3'd1;
            mode_d = M_IDLE;
          end
        end
        M_IDENT: begin
          if (is_alp(c) || is_dig(c) || c == "_") begin
            if (plen_d < PosW'(KwMaxLen))
              kbuf_d[plen_d[KwIdxW-1:0]] = (c >= "a" && c <= "z") ? c - 8'd32 : c;
            plen_d = sat_inc(plen_d);
          end else begin
            k = (plen_d <= PosW'(KwMaxLen)) ? kw_lookup(kbuf_d, plen_d[KwLenW-1:0])
                                             : KindIdent;
            slot[n[1:0]] = mk(k, ErrNone, sline_d, scol_d, plen_d); n = n + 3'd1;
            mode_d = M_IDLE; fresh = 1'b1;
          end
        end
        M_INT: begin
          if (is_dig(c)) plen_d = sat_inc(plen_d);
          else if (c == ".") mode_d = M_INT_DOT;
          else begin
            slot[n[1:0]] = mk(KindInt, ErrNone, sline_d, scol_d, plen_d); n = n + 3'd1;
            mode_d = M_IDLE; fresh = 1'b1;
          end
        end
        M_INT_DOT: begin
          if (is_dig(c)) begin
            plen_d = sat_inc(sat_inc(plen_d));
            mode_d = M_FLOAT;
          end else begin
            slot[n[1:0]] = mk(KindInt, ErrNone, sline_d, scol_d, plen_d); n = n + 3'd1;
            slot[n[1:0]] = mk(KindDot, ErrNone, sline_d, sat_add(scol_d, plen_d), PosW'(1));
            n = n + 3'd1;
            mode_d = M_IDLE; fresh = 1'b1;
          end
        end
        M_FLOAT: begin
          if (is_dig(c)) plen_d = sat_inc(plen_d);
          else begin
            slot[n[1:0]] = mk(KindFloat, ErrNone, sline_d, scol_d, plen_d); n = n + 3'd1;
            mode_d = M_IDLE; fresh = 1'b1;
          end
        end
        default: begin
          mode_d = M_IDLE;
          fresh = 1'b1;
        end
      endcase
    end

    if (fresh) begin
      priority if (c == " " || c == 8'h0d || c == 8'h09 || c == 8'h0a) begin
      end else if (c == "(") begin
        slot[n[1:0]] = mk(KindLParen, ErrNone, line_q, col_q, PosW'(1)); n = n + 3'd1;
      end else if (c == ")") begin
        slot[n[1:0]] = mk(KindRParen, ErrNone, line_q, col_q, PosW'(1)); n = n + 3'd1;
      end else if (c == ",") begin
        slot[n[1:0]] = mk(KindComma, ErrNone, line_q, col_q, PosW'(1)); n = n + 3'd1;
      end else if (c == ".") begin
        slot[n[1:0]] = mk(KindDot, ErrNone, line_q, col_q, PosW'(1)); n = n + 3'd1;
      end else if (c == ";") begin
        slot[n[1:0]] = mk(KindSemi, ErrNone, line_q, col_q, PosW'(1)); n = n + 3'd1;
      end else if (c == "+") begin
        slot[n[1:0]] = mk(KindPlus, ErrNone, line_q, col_q, PosW'(1)); n = n + 3'd1;
      end else if (c == "*") begin
        slot[n[1:0]] = mk(KindStar, ErrNone, line_q, col_q, PosW'(1)); n = n + 3'd1;
      end else if (c == "-" || c == "/" || c == "=" || c == "!" || c == "<" ||
                   c == ">" || c == "|" || c == "'" || c == "\"" || is_dig(c) ||
                   is_alp(c) || c == "_") begin
        sline_d = line_q;
        scol_d  = col_q;
        plen_d  = PosW'(1);
        priority if (c == "-") mode_d = M_MINUS;
        else if (c == "/") mode_d = M_SLASH;
        else if (c == "=") mode_d = M_EQ;
        else if (c == "!") mode_d = M_BANG;
        else if (c == "<") mode_d = M_LT;
        else if (c == ">") mode_d = M_GT;
        else if (c == "|") mode_d = M_BAR;
        else if (c == "'") mode_d = M_STR;
        else if (c == "\"") mode_d = M_QNAME;
        else if (is_dig(c)) mode_d = M_INT;
        else begin
          mode_d = M_IDENT;
          kbuf_d[0] = (c >= "a" && c <= "z") ? c - 8'd32 : c;
        end
      end else begin
        slot[n[1:0]] = mk(KindError, ErrChar, line_q, col_q, PosW'(1)); n = n + 3'd1;
        err_d = 1'b1;
      end
    end

    if (c == 8'h0a) begin
      line_d = sat_inc(line_q);
      col_d  = PosW'(1);
    end else begin
      col_d = sat_inc(col_q);
    end

    if (byte_i.end_of_source) begin
      if (!err_d) begin
        unique case (mode_d)
          M_MINUS: begin
            slot[n[1:0]] = mk(KindMinus, ErrNone, sline_d, scol_d, PosW'(1)); n = n + 3'd1;
          end
          M_SLASH: begin
            slot[n[1:0]] = mk(KindSlash, ErrNone, sline_d, scol_d, PosW'(1)); n = n + 3'd1;
          end
          M_EQ: begin
            slot[n[1:0]] = mk(KindEq, ErrNone, sline_d, scol_d, PosW'(1)); n = n + 3'd1;
          end
          M_BANG: begin
            slot[n[1:0]] = mk(KindError, ErrBang, sline_d, scol_d, PosW'(1)); n = n + 3'd1;
            err_d = 1'b1;
          end
          M_LT: begin
            slot[n[1:0]] = mk(KindLt, ErrNone, sline_d, scol_d, PosW'(1)); n = n + 3'd1;
          end
          M_GT: begin
            slot[n[1:0]] = mk(KindGt, ErrNone, sline_d, scol_d, PosW'(1)); n = n + 3'd1;
          end
          M_BAR: begin
            slot[n[1:0]] = mk(KindError, ErrBar, sline_d, scol_d, PosW'(1)); n = n + 3'd1;
            err_d = 1'b1;
          end
          M_STR: begin
            slot[n[1:0]] = mk(KindError, ErrString, sline_d, scol_d, plen_d); n = n + 3'd1;
            err_d = 1'b1;
          end
          M_STR_Q: begin
            slot[n[1:0]] = mk(KindString, ErrNone, sline_d, scol_d, plen_d); n = n + 3'd1;
          end
          M_QNAME: begin
            slot[n[1:0]] = mk(KindError, ErrQName, sline_d, scol_d, plen_d); n = n + 3'd1;
            err_d = 1'b1;
          end
          M_IDENT: begin
            k = (plen_d <= PosW'(KwMaxLen)) ? kw_lookup(kbuf_d, plen_d[KwLenW-1:0])
                                             : KindIdent;
            slot[n[1:0]] = mk(k, ErrNone, sline_d, scol_d, plen_d); n = n + 3'd1;
          end
          M_INT: begin
            slot[n[1:0]] = mk(KindInt, ErrNone, sline_d, scol_d, plen_d); n = n + 3'd1;
          end
          M_INT_DOT: begin
            slot[n[1:0]] = mk(KindInt, ErrNone, sline_d, scol_d, plen_d); n = n + 3'd1;
            slot[n[1:0]] = mk(KindDot, ErrNone, sline_d, sat_add(scol_d, plen_d), PosW'(1));
            n = n + 3'd1;
          end
          M_FLOAT: begin
            slot[n[1:0]] = mk(KindFloat, ErrNone, sline_d, scol_d, plen_d); n = n + 3'd1;
          end
          default: ;
        endcase
        if (!err_d) begin
          slot[n[1:0]] = mk(KindEnd, ErrNone, line_d, col_d, '0); n = n + 3'd1;
        end
      end
      mode_d  = M_IDLE;
      kbuf_d  = '0;
      line_d  = PosW'(1);
      col_d   = PosW'(1);
      sline_d = PosW'(1);
      scol_d  = PosW'(1);
      plen_d  = '0;
      err_d   = 1'b0;
    end

    li = n[1:0] - 2'd1;
    if (n != 3'd0) slot[li].last = 1'b1;
  end

  assign push_o.cnt  = acc ? n : 3'd0;
  assign push_o.slot = slot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      kbuf_q  <= '0;
      line_q  <= PosW'(1);
      col_q   <= PosW'(1);
      sline_q <= PosW'(1);
      scol_q  <= PosW'(1);
      plen_q  <= '0;
      err_q   <= 1'b0;
    end else if (acc) begin
      mode_q  <= mode_d;
      kbuf_q  <= kbuf_d;
      line_q  <= line_d;
      col_q   <= col_d;
      sline_q <= sline_d;
      scol_q  <= scol_d;
      plen_q  <= plen_d;
      err_q   <= err_d;
    end
  end

endmodule

// ----- rtl/sqlx_queue.sv -----
// Token queue and output stage: takes up to four tokens a beat, sends one.
module sqlx_queue import sqlx_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  push_t      push_i,
  output logic       room_o,
  sqlx_tok_if.source tok_o
);

  tok_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QPtrW:0]   cnt_q;
  logic             pop;

  assign room_o = cnt_q <= (QPtrW+1)'(QDepth - MaxTok);
  assign pop    = tok_o.valid & tok_o.ready;

  assign tok_o.valid        = cnt_q != '0;
  assign tok_o.token_kind   = mem_q[rd_q].kind;
  assign tok_o.error_code   = mem_q[rd_q].err;
  assign tok_o.start_line   = mem_q[rd_q].line;
  assign tok_o.start_column = mem_q[rd_q].col;
  assign tok_o.token_length = mem_q[rd_q].len;
  assign tok_o.last_of_run  = mem_q[rd_q].last;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxTok; i++) begin
      if (i < int'(push_i.cnt)) mem_q[wr_q + QPtrW'(i)] <= push_i.slot[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + QPtrW'(push_i.cnt);
      rd_q  <= rd_q + QPtrW'(pop);
      cnt_q <= cnt_q + (QPtrW+1)'(push_i.cnt) - (QPtrW+1)'(pop);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= (QPtrW+1)'(QDepth))
    else $error("token queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.cnt != 3'd0) |-> room_o)
    else $error("push without room");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.cnt == 3'd0 && !pop) |=> $stable(cnt_q) && $stable(rd_q))
    else $error("queue moved while idle");

endmodule

// ----- rtl/sql_token_lexer.sv -----
// SQL token lexer top level: byte scanner feeding a token queue.
//   channel  dir  beat
//   byte_i   in   data_byte, end_of_source
//   tok_o    out  token_kind, error_code, start_line/column, token_length, last_of_run
// One byte per cycle unless stalled; tokens are queued, one leaves per tok_o handshake.
// The scanner stalls byte_i while the 8-entry queue has fewer than 4 free slots.
// tok_o stalls hold the queue head and stop scanning only once under 4 slots are free.
// Reset returns the scanner to line 1, column 1 and empties the queue.
module sql_token_lexer import sqlx_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  sqlx_byte_if.sink  byte_i,
  sqlx_tok_if.source tok_o
);

  push_t push;
  logic  room;

  sqlx_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_i),
    .room_i (room),
    .push_o (push)
  );

  sqlx_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .tok_o  (tok_o)
  );

endmodule

// ----- tb/sv/tb.sv -----
// Testbench for the SQL token lexer: byte driver, token monitor and lexer predictor.
`timescale 1ns / 100ps

module tb;
  import sqlx_pkg::*;

  typedef enum logic [4:0] {
    LxIdle, LxMinus, LxLine, LxSlash, LxBlock, LxBlockStar, LxEq, LxBang,
    LxLt, LxGt, LxBar, LxStr, LxStrQ, LxQName, LxIdent, LxInt, LxIntDot, LxFloat
  } lx_mode_e;

  typedef struct packed {
    logic [7:0] data;
    logic       eos;
  } src_byte_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  sqlx_byte_if byte_if ();
  sqlx_tok_if  tok_if ();

  sql_token_lexer i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_if),
    .tok_o  (tok_if)
  );

  always #5 clk_i = ~clk_i;

  src_byte_t pending_bytes[$];
  tok_t      expected_toks[$];
  int        n_errors = 0;
  bit        stim_done = 1'b0;
  bit        drain_wait = 1'b0;
  int        hold_cycles = 0;
  bit        byte_taken = 1'b0;

  // predictor state
  lx_mode_e        p_mode;
  kbuf_t           p_kbuf;
  logic [PosW-1:0] p_line, p_col, p_tline, p_tcol, p_len;
  bit              p_err;
  tok_t            step_toks[$];

  function automatic logic [PosW-1:0] sat1(logic [PosW-1:0] v);
    return (v == PosMax) ? v : v + 1'b1;
  endfunction

  function automatic logic [PosW-1:0] sat_sum(logic [PosW-1:0] a, logic [PosW-1:0] b);
    logic [PosW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[PosW] ? PosMax : s[PosW-1:0];
  endfunction

  function automatic bit is_dig(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alf(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic void lexer_clear();
    p_mode = LxIdle; p_kbuf = '0; p_line = 1; p_col = 1; p_tline = 1; p_tcol = 1;
    p_len = 0; p_err = 0;
  endfunction

  function automatic void push_tok(logic [5:0] k, logic [2:0] e, logic [PosW-1:0] l,
                                   logic [PosW-1:0] c, logic [PosW-1:0] n);
    tok_t t;
    t.kind = k; t.err = e; t.line = l; t.col = c; t.len = n; t.last = 1'b0;
    if (step_toks.size() < MaxTok) step_toks = {step_toks, t};
  endfunction

  function automatic void push_held(logic [5:0] k, logic [PosW-1:0] n);
    push_tok(k, ErrNone, p_tline, p_tcol, n);
    p_mode = LxIdle;
  endfunction

  function automatic void raise_err(logic [2:0] e, logic [PosW-1:0] n);
    push_tok(KindError, e, p_tline, p_tcol, n);
    p_err = 1; p_mode = LxIdle;
  endfunction

  function automatic void open_tok(lx_mode_e m);
    p_tline = p_line; p_tcol = p_col; p_len = 1; p_mode = m;
  endfunction

  function automatic void take_letter(logic [7:0] c);
    logic [7:0] u;
    u = (c >= "a" && c <= "z") ? c - 8'd32 : c;
    if (p_len < KwMaxLen) p_kbuf[p_len[KwIdxW-1:0]] = u;
    p_len = sat1(p_len);
  endfunction

  function automatic void push_word();
    logic [5:0] k;
    bit ok;
    k = KindIdent;
    if (p_len <= KwMaxLen) begin
      for (int j = 0; j < NumKw && k == KindIdent; j++) begin
        ok = (p_len == KwLen[j]);
        for (int i = 0; i < KwLen[j] && ok; i++) begin
          if (p_kbuf[i] != KwTab[j][8*(KwLen[j]-1-i) +: 8]) ok = 0;
        end
        if (ok) k = 6'(int'(KindKw0) + j);
      end
    end
    push_held(k, p_len);
  endfunction

  function automatic void start_fresh(logic [7:0] c);
    case (c)
      " ", 8'h0d, 8'h09, 8'h0a: ;
      "(": push_tok(KindLParen, ErrNone, p_line, p_col, 1);
      ")": push_tok(KindRParen, ErrNone, p_line, p_col, 1);
      ",": push_tok(KindComma, ErrNone, p_line, p_col, 1);
      ".": push_tok(KindDot, ErrNone, p_line, p_col, 1);
      ";": push_tok(KindSemi, ErrNone, p_line, p_col, 1);
      "+": push_tok(KindPlus, ErrNone, p_line, p_col, 1);
      "*": push_tok(KindStar, ErrNone, p_line, p_col, 1);
      "-": open_tok(LxMinus);
      "/": open_tok(LxSlash);
      "=": open_tok(LxEq);
      "!": open_tok(LxBang);
      "<": open_tok(LxLt);
      ">": open_tok(LxGt);
      "|": open_tok(LxBar);
      "'": open_tok(LxStr);
      "\"": open_tok(LxQName);
      default: begin
        if (is_dig(c)) open_tok(LxInt);
        else if (is_alf(c) || c == "_") begin
          open_tok(LxIdent);
          p_len = 0;
          take_letter(c);
        end else begin
          p_tline = p_line; p_tcol = p_col;
          raise_err(ErrChar, 1);
        end
      end
    endcase
  endfunction

  function automatic void scan_byte(logic [7:0] c);
    case (p_mode)
      LxMinus: if (c == "-") p_mode = LxLine; else begin push_held(KindMinus, 1); start_fresh(c); end
      LxLine: if (c == 8'h0a) p_mode = LxIdle;
      LxSlash: if (c == "*") p_mode = LxBlock; else begin push_held(KindSlash, 1); start_fresh(c); end
      LxBlock: if (c == "*") p_mode = LxBlockStar;
      LxBlockStar: if (c == "/") p_mode = LxIdle; else if (c != "*") p_mode = LxBlock;
      LxEq: if (c == "=") push_held(KindEq, 2); else begin push_held(KindEq, 1); start_fresh(c); end
      LxBang: if (c == "=") push_held(KindNe, 2); else raise_err(ErrBang, 1);
      LxLt: begin
        if (c == "=") push_held(KindLe, 2);
        else if (c == ">") push_held(KindNe, 2);
        else begin push_held(KindLt, 1); start_fresh(c); end
      end
      LxGt: if (c == "=") push_held(KindGe, 2); else begin push_held(KindGt, 1); start_fresh(c); end
      LxBar: if (c == "|") push_held(KindConcat, 2); else raise_err(ErrBar, 1);
      LxStr: begin
        p_len = sat1(p_len);
        if (c == "'") p_mode = LxStrQ;
      end
      LxStrQ: begin
        if (c == "'") begin p_len = sat1(p_len); p_mode = LxStr; end
        else begin push_held(KindString, p_len); start_fresh(c); end
      end
      LxQName: begin
        p_len = sat1(p_len);
        if (c == "\"") push_held(KindQName, p_len);
      end
      LxIdent: begin
        if (is_alf(c) || is_dig(c) || c == "_") take_letter(c);
        else begin push_word(); start_fresh(c); end
      end
      LxInt: begin
        if (is_dig(c)) p_len = sat1(p_len);
        else if (c == ".") p_mode = LxIntDot;
        else begin push_held(KindInt, p_len); start_fresh(c); end
      end
      LxIntDot: begin
        if (is_dig(c)) begin p_len = sat1(sat1(p_len)); p_mode = LxFloat; end
        else begin
          push_held(KindInt, p_len);
          push_tok(KindDot, ErrNone, p_tline, sat_sum(p_tcol, p_len), 1);
          start_fresh(c);
        end
      end
      LxFloat: begin
        if (is_dig(c)) p_len = sat1(p_len);
        else begin push_held(KindFloat, p_len); start_fresh(c); end
      end
      default: begin p_mode = LxIdle; start_fresh(c); end
    endcase
  endfunction

  function automatic void flush_held();
    case (p_mode)
      LxMinus: push_held(KindMinus, 1);
      LxSlash: push_held(KindSlash, 1);
      LxEq: push_held(KindEq, 1);
      LxBang: raise_err(ErrBang, 1);
      LxLt: push_held(KindLt, 1);
      LxGt: push_held(KindGt, 1);
      LxBar: raise_err(ErrBar, 1);
      LxStr: raise_err(ErrString, p_len);
      LxStrQ: push_held(KindString, p_len);
      LxQName: raise_err(ErrQName, p_len);
      LxIdent: push_word();
      LxInt: push_held(KindInt, p_len);
      LxIntDot: begin
        push_held(KindInt, p_len);
        push_tok(KindDot, ErrNone, p_tline, sat_sum(p_tcol, p_len), 1);
      end
      LxFloat: push_held(KindFloat, p_len);
      default: p_mode = LxIdle;
    endcase
  endfunction

  function automatic void predict_tokens(src_byte_t b);
    tok_t t;
    step_toks.delete();
    if (!p_err) scan_byte(b.data);
    if (b.data == 8'h0a) begin p_line = sat1(p_line); p_col = 1; end
    else p_col = sat1(p_col);
    if (b.eos) begin
      if (!p_err) flush_held();
      if (!p_err) push_tok(KindEnd, ErrNone, p_line, p_col, 0);
      lexer_clear();
    end
    for (int i = 0; i < step_toks.size(); i++) begin
      t = step_toks[i];
      t.last = (i == step_toks.size() - 1);
      expected_toks = {expected_toks, t};
    end
  endfunction

  task automatic report_mismatch(string what, logic [PosW-1:0] got, logic [PosW-1:0] want);
    n_errors++;
    $display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
  endtask

  // byte beats are taken at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && byte_if.valid && byte_if.ready) begin
      predict_tokens({byte_if.data_byte, byte_if.end_of_source});
      byte_taken = 1'b1;
    end
  end

  // byte driver
  int gap = 0;
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_if.valid <= 1'b0;
      byte_if.data_byte <= '0;
      byte_if.end_of_source <= 1'b0;
      gap = 0;
      byte_taken = 1'b0;
    end else if (!byte_if.valid || byte_taken) begin
      if (byte_taken) begin
        byte_taken = 1'b0;
        void'(pending_bytes.pop_front());
        gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 16) : 0;
      end
      if (gap > 0 || (drain_wait && expected_toks.size() != 0) || pending_bytes.size() == 0)
      begin
        if (gap > 0) gap--;
        byte_if.valid <= 1'b0;
      end else begin
        byte_if.valid <= 1'b1;
        byte_if.data_byte <= pending_bytes[0].data;
        byte_if.end_of_source <= pending_bytes[0].eos;
      end
    end
  end

  // token monitor and receiver stalls
  int rx_wait = 0;
  tok_t want;
  always @(posedge clk_i) begin
    if (rst_ni && tok_if.valid && tok_if.ready) begin
      if (expected_toks.size() == 0) begin
        report_mismatch("unexpected token kind", PosW'(tok_if.token_kind), '0);
      end else begin
        want = expected_toks.pop_front();
        if (tok_if.token_kind != want.kind)
          report_mismatch("kind", PosW'(tok_if.token_kind), PosW'(want.kind));
        if (tok_if.error_code != want.err)
          report_mismatch("error", PosW'(tok_if.error_code), PosW'(want.err));
        if (tok_if.start_line != want.line) report_mismatch("line", tok_if.start_line, want.line);
        if (tok_if.start_column != want.col) report_mismatch("column", tok_if.start_column, want.col);
        if (tok_if.token_length != want.len) report_mismatch("length", tok_if.token_length, want.len);
        if (tok_if.last_of_run != want.last)
          report_mismatch("last", PosW'(tok_if.last_of_run), PosW'(want.last));
      end
      rx_wait = $urandom_range(0, 3) == 0 ? $urandom_range(0, 16) : 0;
    end
  end

  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_if.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles--;
      tok_if.ready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      tok_if.ready <= 1'b0;
    end else begin
      tok_if.ready <= 1'b1;
    end
  end

  task automatic add_text(string s, bit eos);
    src_byte_t b;
    for (int i = 0; i < s.len(); i++) begin
      b.data = s[i];
      b.eos = eos && (i == s.len() - 1);
      pending_bytes = {pending_bytes, b};
    end
  endtask

  function automatic string pick_frag();
    string frags[30];
    string s;
    frags = '{"SELECT", "from", "WhErE", "between", "PRIMARY", "primaryx", "as", "_a9",
              "12", "3.25", "7.", "'it''s'", "\"col\"", "<=", "<>", ">=", "==", "!=",
              "||", "(", ")", ",", ";", "+", "*", "-", "/", "--c\n", "/* x **/", "\n"};
    s = frags[$urandom_range(0, 29)];
    if ($urandom_range(0, 3) == 0) s = {s, " "};
    return s;
  endfunction

  task automatic wait_drained();
    while (pending_bytes.size() != 0 || expected_toks.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    string s;
    src_byte_t b;
    int n;
    lexer_clear();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed sources
    add_text("SELECT a_1,\"Q\" FROM t WHERE x<=1.5 AND y<>'a''b'||z;", 1);
    add_text("1.x 2. (3)*-4/5>=6>7<8=9==0 != -- note\n/* c */ DESC", 1);
    add_text("between primary selectx", 1);
    add_text("a\t\r\n/* open", 1);
    add_text("-- open", 1);
    add_text("x ! y", 1);
    add_text("|", 1);
    add_text("'open", 1);
    add_text("\"open", 1);
    add_text("a # b", 1);
    b.data = 8'hff; b.eos = 1; pending_bytes = {pending_bytes, b};
    b.data = 8'h80; b.eos = 1; pending_bytes = {pending_bytes, b};
    add_text("7.", 1);
    add_text("'ok'", 1);
    wait_drained();

    // receiver held off while bytes keep coming
    add_text("(a,b);((((((((", 1);
    hold_cycles = 80;
    wait_drained();

    // random sources, sender waits for all tokens after each one
    n = 0;
    while (n < 12) begin
      s = "";
      repeat ($urandom_range(1, 8)) begin
        if ($urandom_range(0, 9) == 0) s = {s, string'(8'($urandom_range(0, 255)))};
        else s = {s, pick_frag()};
      end
      add_text(s, 1);
      n += s.len();
      drain_wait = 1'b1;
      wait_drained();
      drain_wait = 1'b0;
    end
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (n_errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #2ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
